>>> rtl/lsrs_pkg.sv
// ----------------------------------------------------------------------------
// Lattice sieve recurrence setup package
// Shared widths, constants and the divider request type.
// ----------------------------------------------------------------------------
package lsrs_pkg;

    localparam int WORD_BITS = 32;
    localparam int RLOG_BITS = 4;
    localparam int UB_BITS   = 15;
    localparam int CNT_BITS  = 6;

    localparam logic [RLOG_BITS-1:0] RLOG_RESET = 4'd15;
    localparam logic [UB_BITS-1:0]   UB_RESET   = 15'd256;

    localparam logic CFG_RANGE_LOG2 = 1'b0;
    localparam logic CFG_TIME_BOUND = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

endpackage

>>> rtl/lsrs_div.sv
// ----------------------------------------------------------------------------
// Lattice sieve recurrence setup divider
// Restoring radix-2 divider, one quotient bit per cycle. A zero divisor gives
// an all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
module lsrs_div
    import lsrs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output logic     o_done,
    output t_word    o_quot,
    output t_word    o_rem
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    t_word               r_q, n_q;
    t_word               r_r, n_r;
    t_word               r_d, n_d;
    logic [WORD_BITS:0]  trial;
    logic [WORD_BITS:0]  diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        trial  = {r_r, r_q[WORD_BITS-1]};
        diff   = trial - {1'b0, r_d};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_r    = '0;
            n_d    = i_req.divisor;
        end else if (r_busy) begin
            // Remainder shifts in one dividend bit; quotient bit fills the low end.
            if (!diff[WORD_BITS]) begin
                n_r = diff[WORD_BITS-1:0];
                n_q = {r_q[WORD_BITS-2:0], 1'b1};
            end else begin
                n_r = trial[WORD_BITS-1:0];
                n_q = {r_q[WORD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

>>> rtl/lattice_sieve_recurrence_setup_core.sv
// ----------------------------------------------------------------------------
// Lattice sieve recurrence setup core
// Reduces a factor-base prime and root to two packed recurrence words.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low; the result shows
// on o_first_word and o_second_word with o_done, which is high for one cycle,
// and cannot be held off. Zero-root and root-not-below-prime requests go straight
// to the pack and output states. Other requests run an alternating Euclid
// reduction on one shared restoring divider and one 32x32 multiplier: each
// reduction step passes through the check, divide and first multiply states,
// and the final step adds the second multiply, two clamp, pack and output
// states. The next request can be taken at the edge that ends the result
// cycle. Configuration writes are always accepted and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module lattice_sieve_recurrence_setup_core
    import lsrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_word                i_prime,
    input  t_word                i_root,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  t_word                i_cfg_data,
    output logic                 o_done,
    output t_word                o_first_word,
    output t_word                o_second_word
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;  // test b or c against A
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;  // k * s or k * t
    localparam logic [3:0] ST_MUL2  = 4'd4;  // k * b or k * c
    localparam logic [3:0] ST_CLMP1 = 4'd5;
    localparam logic [3:0] ST_CLMP2 = 4'd6;
    localparam logic [3:0] ST_PACK  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]           r_state, n_state;
    logic [RLOG_BITS-1:0] r_rlog;
    logic [UB_BITS-1:0]   r_ub;
    t_word                r_b, n_b, r_c, n_c, r_s, n_s, r_t, n_t, r_d, n_d;
    t_word                r_k, n_k;
    logic                 r_side, n_side;   // 0: reduce c by b, 1: reduce b by c
    logic                 r_fin, n_fin;     // final step, k is quotient + 1
    logic                 r_done, n_done;
    t_word                r_w0, n_w0, r_w1, n_w1;
    t_div_req             div_req;
    logic                 div_done;
    t_word                div_q, div_r;
    t_word                a_val, ub2, mul_a, mul_b;
    logic [2*WORD_BITS-1:0] mul_full;

    assign a_val = t_word'(1) << r_rlog;
    assign ub2   = {{(WORD_BITS-UB_BITS-1){1'b0}}, r_ub, 1'b0};
    assign mul_full = mul_a * mul_b;

    lsrs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_q),
        .o_rem  (div_r)
    );

    always_comb begin
        n_state = r_state;
        n_b = r_b; n_c = r_c; n_s = r_s; n_t = r_t; n_d = r_d;
        n_k = r_k; n_side = r_side; n_fin = r_fin;
        n_done = 1'b0; n_w0 = r_w0; n_w1 = r_w1;
        div_req = '0;
        mul_a = r_k;
        mul_b = r_side ? r_t : r_s;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_root == '0) begin
                        n_b = 32'd1; n_s = ub2 + 32'd1; n_c = a_val - 32'd3; n_t = ub2;
                        n_state = ST_PACK;
                    end else if (i_root >= i_prime) begin
                        n_b = 32'd1; n_s = '0; n_c = a_val - 32'd1; n_t = ub2 + 32'd1;
                        n_state = ST_PACK;
                    end else begin
                        n_b = i_root; n_s = 32'd1; n_c = i_prime; n_t = '0;
                        n_side = 1'b0;
                        n_state = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                div_req.start = 1'b1;
                if (!r_side) begin
                    n_fin = r_b < a_val;
                    div_req.dividend = n_fin ? r_c - a_val : r_c;
                    div_req.divisor  = r_b;
                end else begin
                    n_fin = r_c < a_val;
                    div_req.dividend = n_fin ? r_b - a_val : r_b;
                    div_req.divisor  = r_c;
                end
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_k = r_fin ? div_q + 32'd1 : div_q;
                    if (!r_fin) begin
                        if (!r_side) n_c = div_r;
                        else         n_b = div_r;
                    end
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (!r_side) n_t = r_t + mul_full[WORD_BITS-1:0];
                else         n_s = r_s + mul_full[WORD_BITS-1:0];
                if (r_fin) begin
                    n_state = ST_MUL2;
                end else begin
                    n_side  = ~r_side;
                    n_state = ST_CHK;
                end
            end
            ST_MUL2: begin
                mul_b = r_side ? r_c : r_b;
                if (!r_side) n_c = r_c - mul_full[WORD_BITS-1:0];
                else         n_b = r_b - mul_full[WORD_BITS-1:0];
                n_state = ST_CLMP1;
            end
            ST_CLMP1: begin
                n_d = r_t - r_s;
                if (r_s > ub2) n_s = ub2 + 32'd2 - {31'd0, r_s[0]};
                n_state = ST_CLMP2;
            end
            ST_CLMP2: begin
                if (r_t > ub2) begin
                    if (r_d[WORD_BITS-1] || r_d > ub2) begin
                        n_t = r_s + ub2 + 32'd2 + {31'd0, r_s[0]} - {31'd0, r_t[0]};
                    end else begin
                        n_t = r_s + r_d;
                    end
                end
                n_state = ST_PACK;
            end
            ST_PACK: begin
                n_w0 = (r_s << r_rlog) + r_b;
                n_w1 = (r_t << r_rlog) - r_c;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_rlog  <= RLOG_RESET;
            r_ub    <= UB_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RANGE_LOG2) r_rlog <= i_cfg_data[RLOG_BITS-1:0];
                if (i_cfg_index == CFG_TIME_BOUND) r_ub <= i_cfg_data[UB_BITS-1:0];
            end
        end
        r_b <= n_b; r_c <= n_c; r_s <= n_s; r_t <= n_t; r_d <= n_d;
        r_k <= n_k; r_side <= n_side; r_fin <= n_fin;
        r_w0 <= n_w0; r_w1 <= n_w1;
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_done        = r_done;
    assign o_first_word  = r_w0;
    assign o_second_word = r_w1;

endmodule

>>> dv/lattice_sieve_recurrence_setup_core_test.sv
// ----------------------------------------------------------------------------
// Lattice sieve recurrence setup core testbench
// Drives prime and root requests through the start/busy handshake, predicts
// both packed recurrence words in a local model of the reduction, and checks
// every o_done result in order across several configuration settings.
// ----------------------------------------------------------------------------
module lattice_sieve_recurrence_setup_core_test;
    import lsrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    logic  o_busy;
    t_word i_prime;
    t_word i_root;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    logic  i_cfg_index;
    t_word i_cfg_data;
    logic  o_done;
    t_word o_first_word;
    t_word o_second_word;

    lattice_sieve_recurrence_setup_core i_dut (.*);

    typedef struct {
        t_word first_word;
        t_word second_word;
    } t_words;

    t_words                words_due[$];
    logic [RLOG_BITS-1:0]  model_rlog;
    logic [UB_BITS-1:0]    model_ub;
    int                    error_count;
    int                    idle_cycles;
    bit                    steady_sender;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_word div_quot(t_word x, t_word y);
        return (y == 0) ? '1 : x / y;
    endfunction

    function automatic t_word div_rem(t_word x, t_word y);
        return (y == 0) ? x : x % y;
    endfunction

    // Packed recurrence words for one prime and root under the current model settings.
    function automatic t_words recurrence_words(t_word p, t_word r);
        t_word  a_width;
        t_word  ub2;
        t_word  b, c, s, t, k, d;
        t_words w;
        a_width = t_word'(1) << model_rlog;
        ub2 = 2 * t_word'(model_ub);
        if (r == 0) begin
            b = 1; s = ub2 + 1; c = a_width - 3; t = ub2;
        end else if (r >= p) begin
            b = 1; s = 0; c = a_width - 1; t = ub2 + 1;
        end else begin
            b = r; s = 1; c = p; t = 0;
            forever begin
                if (b < a_width) begin
                    k = div_quot(c - a_width, b) + 1;
                    t += k * s;
                    c -= k * b;
                    break;
                end
                k = div_quot(c, b);
                c = div_rem(c, b);
                t += k * s;
                if (c < a_width) begin
                    k = div_quot(b - a_width, c) + 1;
                    s += k * t;
                    b -= k * c;
                    break;
                end
                k = div_quot(b, c);
                b = div_rem(b, c);
                s += k * t;
            end
            d = t - s;
            if (s > ub2)
                s = ub2 + 2 - t_word'(s[0]);
            if (t > ub2) begin
                if (d[31] || d > ub2)
                    d = ub2 + 2 + t_word'(s[0]) - t_word'(t[0]);
                t = s + d;
            end
        end
        w.first_word = (s << model_rlog) + b;
        w.second_word = (t << model_rlog) - c;
        return w;
    endfunction

    task automatic report_mismatch(string what, t_word got, t_word want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    // Start stays high after a request is taken; it drops only while idling
    // or draining, so each edge sees at most one update of the drive signals.
    task automatic send_request(t_word p, t_word r);
        if (!steady_sender) begin
            while ($urandom_range(99) < 31) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_prime <= p;
        i_root  <= r;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        words_due.push_back(recurrence_words(p, r));
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, t_word data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_RANGE_LOG2)
            model_rlog = data[RLOG_BITS-1:0];
        else
            model_ub = data[UB_BITS-1:0];
    endtask

    // Result checker: the receiver can never stall, so each strobe is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (words_due.size() == 0) begin
                $display("unexpected result %h %h", o_first_word, o_second_word);
                error_count++;
            end else begin
                if (o_first_word !== words_due[0].first_word)
                    report_mismatch("first_word", o_first_word, words_due[0].first_word);
                if (o_second_word !== words_due[0].second_word)
                    report_mismatch("second_word", o_second_word,
                                    words_due[0].second_word);
                void'(words_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("lattice_sieve_recurrence_setup_core_test: errors");
            $finish;
        end
    end

    function automatic t_word rand_word();
        case ($urandom_range(3))
            0: return $urandom_range(255);
            1: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_special_cases();
        send_request(0, 0);
        send_request(32'hFFFF_FFFB, 0);
        send_request(7, 7);
        send_request(7, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFB, 1);
        send_request(32'hFFFF_FFFB, 32'hFFFF_FFFA);
        send_request(1_000_003, 2);
        send_request(65_537, 3);
        send_request(4_294_967_291, 2_147_483_648);
        send_request(3, 1);
    endtask

    task automatic test_range_extremes();
        write_register(CFG_RANGE_LOG2, 1);
        write_register(CFG_TIME_BOUND, 2);
        send_request(101, 37);
        send_request(0, 0);
        send_request(5, 9);
        send_request(4_294_967_291, 123_456_789);
        // A zero range gives a width of one, where the divisor can reach zero.
        write_register(CFG_RANGE_LOG2, 0);
        write_register(CFG_TIME_BOUND, 16384);
        send_request(101, 37);
        send_request(0, 0);
        send_request(12, 8);
        write_register(CFG_TIME_BOUND, 32'h0000_7FFF);
        send_request(1009, 500);
        write_register(CFG_TIME_BOUND, 32'hFFFF_0000);
        send_request(1009, 500);
    endtask

    task automatic test_random_requests(int count);
        t_word p, r;
        for (int n = 0; n < count; n++) begin
            steady_sender = (n % 250) >= 200;
            p = rand_word();
            case ($urandom_range(9))
                0: r = 0;
                1: r = p + $urandom_range(3);
                2: r = $urandom;
                default: r = (p == 0) ? 0 : $urandom % p;
            endcase
            send_request(p, r);
        end
        steady_sender = 1'b0;
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 5; phase++) begin
            write_register(CFG_RANGE_LOG2, (phase == 0) ? 15 : $urandom_range(15, 1));
            write_register(CFG_TIME_BOUND, (phase == 1) ? 16384 : $urandom_range(16384, 2));
            test_random_requests(240);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_prime     = '0;
        i_root      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RANGE_LOG2;
        i_cfg_data  = '0;
        model_rlog  = RLOG_RESET;
        model_ub    = UB_RESET;
        error_count = 0;
        idle_cycles = 0;
        steady_sender = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_range_extremes();
        test_random_settings();

        wait_drained();
        if (error_count == 0)
            $display("lattice_sieve_recurrence_setup_core_test: clean");
        else
            $display("lattice_sieve_recurrence_setup_core_test: errors");
        $finish;
    end

endmodule
